>>> src/adc_button_filter_debounce_unit_defines.svh
// Assertion macros shared by the checker file of the button filter.
// No dependencies; include by bare file name.
`ifndef ADC_BUTTON_FILTER_DEBOUNCE_UNIT_DEFINES_SVH
`define ADC_BUTTON_FILTER_DEBOUNCE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ABFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ABFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/abfd_pkg.sv
// Package for the ADC button filter: widths, reset values, register indexes
// and transaction structs. No dependencies.
`timescale 1ns / 1ps

package abfd_pkg;

  localparam int FILTER_SHIFT = 3;
  localparam int TICK_US      = 100;
  localparam int VAL_W        = 10;
  localparam int TIME_W       = 20;
  localparam int ACC_W        = VAL_W + FILTER_SHIFT;
  localparam int REG_IDX_W    = 3;

  localparam logic [VAL_W-1:0]  OUT_UP        = VAL_W'(1023);
  localparam logic [ACC_W-1:0]  ACC_RESET     = ACC_W'(OUT_UP) << FILTER_SHIFT;
  localparam logic [TIME_W-1:0] DEBOUNCE_RST  = TIME_W'(5000);

  localparam logic [REG_IDX_W-1:0] REG_PRESS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CEILING  = 3'd4;

  typedef struct packed {
    logic [VAL_W-1:0]  press_threshold;
    logic [VAL_W-1:0]  release_threshold;
    logic [TIME_W-1:0] debounce_time_us;
    logic [TIME_W-1:0] repeat_time_us;
    logic [VAL_W-1:0]  valid_ceiling;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic [VAL_W-1:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] filtered_value;
    logic [1:0]       button_state;
    logic [VAL_W-1:0] read_value;
    logic             read_valid;
  } out_t;

endpackage

>>> src/abfd_core.sv
// Leaky integrator, debounce/auto-repeat state machine and published value.
// Depends on abfd_pkg.
`timescale 1ns / 1ps

module abfd_core import abfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic step,
  input  in_t  item,
  output out_t result
);

  typedef enum logic [1:0] {
    ST_UP      = 2'd0,
    ST_DEB     = 2'd1,
    ST_PRESSED = 2'd2
  } state_t;

  state_t             state, state_next;
  logic [ACC_W-1:0]   accum, accum_next;
  logic [TIME_W-1:0]  elapsed, elapsed_next;
  logic [VAL_W-1:0]   held, held_next;
  logic [VAL_W-1:0]   published, published_next;

  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_new;
  logic [VAL_W-1:0]   filt_new;
  logic [TIME_W:0]    time_sum;
  logic [TIME_W-1:0]  elapsed_inc;

  assign acc_sum  = {1'b0, accum} - ({1'b0, accum} >> FILTER_SHIFT)
                    + (ACC_W+1)'(item.adc_sample);
  assign acc_new  = acc_sum[ACC_W-1:0];
  assign filt_new = acc_new[ACC_W-1:FILTER_SHIFT];

  // saturating tick add
  assign time_sum    = {1'b0, elapsed} + (TIME_W+1)'(TICK_US);
  assign elapsed_inc = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

  always_comb begin
    state_next     = state;
    accum_next     = accum;
    elapsed_next   = elapsed;
    held_next      = held;
    published_next = published;
    result         = '0;
    if (!item.mode) begin
      accum_next = acc_new;
      unique case (state)
        ST_DEB: begin
          if (elapsed < cfg.debounce_time_us) begin
            elapsed_next = elapsed_inc;
          end else begin
            held_next      = filt_new;
            published_next = filt_new;
            elapsed_next   = '0;
            state_next     = ST_PRESSED;
          end
        end
        ST_PRESSED: begin
          if (filt_new >= cfg.release_threshold) begin
            state_next = ST_UP;
          end else if (cfg.repeat_time_us != '0) begin
            if (elapsed < cfg.repeat_time_us) begin
              elapsed_next = elapsed_inc;
            end else begin
              published_next = held;
              elapsed_next   = '0;
            end
          end
        end
        default: begin
          state_next = ST_UP;
          if (filt_new <= cfg.press_threshold) begin
            elapsed_next = '0;
            state_next   = ST_DEB;
          end
        end
      endcase
      result.filtered_value = filt_new;
      result.button_state   = state_next;
    end else begin
      published_next        = OUT_UP;
      result.filtered_value = accum[ACC_W-1:FILTER_SHIFT];
      result.button_state   = state;
      result.read_value     = published;
      result.read_valid     = (published <= cfg.valid_ceiling);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_UP;
      accum     <= ACC_RESET;
      elapsed   <= '0;
      held      <= '0;
      published <= OUT_UP;
    end else if (step) begin
      state     <= state_next;
      accum     <= accum_next;
      elapsed   <= elapsed_next;
      held      <= held_next;
      published <= published_next;
    end
  end

endmodule

>>> src/adc_button_filter_debounce_unit.sv
// Top level of the ADC button filter: APB register file, core and output stage.
// Depends on abfd_pkg and abfd_core.
//
//   channel | signals                         | transaction when
//   --------+---------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_item     | in_valid && !in_stall
//   output  | out_valid, out_stall, out_item  | out_valid && !out_stall
//   config  | psel, penable, pwrite, paddr... | psel && penable && pwrite
//
// One transaction per cycle on each channel unless in_stall or out_stall holds it;
// each accepted result is registered after the core logic in the output register
// or, while that register is held, in a skid register, so in_stall rises only when
// both the output and skid registers are full.
// Synchronous reset restores state and registers and empties both output stages.
`timescale 1ns / 1ps

module adc_button_filter_debounce_unit import abfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_item
);

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 accept;
  logic                 take;
  logic                 skid_valid;
  out_t                 skid_item;
  out_t                 result;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_threshold   <= '0;
      cfg.release_threshold <= OUT_UP;
      cfg.debounce_time_us  <= DEBOUNCE_RST;
      cfg.repeat_time_us    <= '0;
      cfg.valid_ceiling     <= OUT_UP;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_PRESS:    cfg.press_threshold   <= pwdata[VAL_W-1:0];
        REG_RELEASE:  cfg.release_threshold <= pwdata[VAL_W-1:0];
        REG_DEBOUNCE: cfg.debounce_time_us  <= pwdata[TIME_W-1:0];
        REG_REPEAT:   cfg.repeat_time_us    <= pwdata[TIME_W-1:0];
        REG_CEILING:  cfg.valid_ceiling     <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRESS:    prdata = 32'(cfg.press_threshold);
      REG_RELEASE:  prdata = 32'(cfg.release_threshold);
      REG_DEBOUNCE: prdata = 32'(cfg.debounce_time_us);
      REG_REPEAT:   prdata = 32'(cfg.repeat_time_us);
      REG_CEILING:  prdata = 32'(cfg.valid_ceiling);
      default:      prdata = '0;
    endcase
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  abfd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (accept),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_item   <= skid_item;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_item  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_item  <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule

>>> src/abfd_checker.sv
// Port-level checker for the ADC button filter top level, with its bind.
// Depends on abfd_pkg and adc_button_filter_debounce_unit_defines.svh.
`timescale 1ns / 1ps
`include "adc_button_filter_debounce_unit_defines.svh"

module abfd_checker import abfd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_item
);

  `ABFD_ASSERT_NOW(a_reset_empty, $fell(rst), !out_valid && !in_stall, "stages not empty after reset")
  `ABFD_ASSERT_NOW(a_stall_full, in_stall, out_valid, "input stalled with output empty")
  `ABFD_ASSERT_NEXT(a_drain_frees, out_valid && !out_stall, !in_stall, "skid not freed after output taken")
  `ABFD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind adc_button_filter_debounce_unit abfd_checker u_abfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> tb/sv/testbench.sv
// Testbench for adc_button_filter_debounce_unit: a self-checking run of directed and random
// ADC ticks and reads, with APB register settings, random input gaps and random output back-pressure.
// Depends on abfd_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import abfd_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int IDLE_LIMIT = 3000;

  localparam logic       MODE_TICK   = 1'b0;
  localparam logic       MODE_READ   = 1'b1;
  localparam logic [1:0] BTN_UP      = 2'd0;
  localparam logic [1:0] BTN_DEBOUNCE = 2'd1;
  localparam logic [1:0] BTN_PRESSED = 2'd2;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  in_t         in_item;
  logic        out_valid;
  logic        out_stall;
  out_t        out_item;

  // predictor copy of the registers and state
  cfg_t              regs;
  logic [ACC_W-1:0]  integ_acc;
  logic [1:0]        btn_state;
  logic [TIME_W-1:0] elapsed_q;
  logic [VAL_W-1:0]  held_val;
  logic [VAL_W-1:0]  pub_val;

  out_t expected_results[$];
  out_t want_res;
  int   errors = 0;
  int   idle_cycles;
  bit   no_gaps = 0;
  int   hold_cycles = 0;
  int   stall_left = 0;
  logic stall_lvl = 1'b0;
  int   stall_pick;

  adc_button_filter_debounce_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [TIME_W-1:0] elapsed_plus_tick(logic [TIME_W-1:0] e);
    logic [TIME_W:0] s;
    s = {1'b0, e} + (TIME_W + 1)'(TICK_US);
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic out_t filter_step(in_t it);
    out_t r;
    logic [VAL_W-1:0] filt;
    r = '0;
    if (it.mode == MODE_TICK) begin
      integ_acc = integ_acc - (integ_acc >> FILTER_SHIFT) + ACC_W'(it.adc_sample);
      filt = VAL_W'(integ_acc >> FILTER_SHIFT);
      case (btn_state)
        BTN_DEBOUNCE: begin
          if (elapsed_q < regs.debounce_time_us) begin
            elapsed_q = elapsed_plus_tick(elapsed_q);
          end else begin
            held_val  = filt;
            pub_val   = filt;
            elapsed_q = '0;
            btn_state = BTN_PRESSED;
          end
        end
        BTN_PRESSED: begin
          if (filt >= regs.release_threshold) begin
            btn_state = BTN_UP;
          end else if (regs.repeat_time_us != '0) begin
            if (elapsed_q < regs.repeat_time_us) begin
              elapsed_q = elapsed_plus_tick(elapsed_q);
            end else begin
              pub_val   = held_val;
              elapsed_q = '0;
            end
          end
        end
        default: begin
          btn_state = BTN_UP;
          if (filt <= regs.press_threshold) begin
            elapsed_q = '0;
            btn_state = BTN_DEBOUNCE;
          end
        end
      endcase
    end else begin
      filt = VAL_W'(integ_acc >> FILTER_SHIFT);
      r.read_value = pub_val;
      r.read_valid = (pub_val <= regs.valid_ceiling);
      pub_val = OUT_UP;
    end
    r.filtered_value = filt;
    r.button_state   = btn_state;
    return r;
  endfunction

  function automatic in_t tick_item(int v);
    in_t it;
    it.mode = MODE_TICK;
    it.adc_sample = (v < 0) ? '0 : (v > 1023) ? VAL_W'(1023) : VAL_W'(v);
    return it;
  endfunction

  function automatic in_t read_item();
    in_t it;
    it.mode = MODE_READ;
    it.adc_sample = VAL_W'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(filter_step(it));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PRESS:    regs.press_threshold   = val[VAL_W-1:0];
      REG_RELEASE:  regs.release_threshold = val[VAL_W-1:0];
      REG_DEBOUNCE: regs.debounce_time_us  = val[TIME_W-1:0];
      REG_REPEAT:   regs.repeat_time_us    = val[TIME_W-1:0];
      REG_CEILING:  regs.valid_ceiling     = val[VAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(cfg_t c);
    wait_idle();
    apb_write(REG_PRESS,    32'(c.press_threshold));
    apb_write(REG_RELEASE,  32'(c.release_threshold));
    apb_write(REG_DEBOUNCE, 32'(c.debounce_time_us));
    apb_write(REG_REPEAT,   32'(c.repeat_time_us));
    apb_write(REG_CEILING,  32'(c.valid_ceiling));
  endtask

  // reset values, sample extremes, reads at reset
  task automatic test_reset_state();
    send_item(read_item());
    send_item(tick_item(1023));
    send_item(tick_item(0));
    send_item(read_item());
    send_item(tick_item(0));
    send_item(read_item());
  endtask

  // zero debounce, shortest repeat, ceiling and release extremes
  task automatic test_field_extremes();
    cfg_t c;
    c = regs;
    c.press_threshold   = VAL_W'(1023);
    c.release_threshold = VAL_W'(1023);
    c.debounce_time_us  = '0;
    c.repeat_time_us    = TIME_W'(TICK_US);
    c.valid_ceiling     = '0;
    set_config(c);
    send_item(tick_item(0));
    send_item(tick_item(1023));
    send_item(tick_item(512));
    send_item(tick_item(512));
    send_item(read_item());
    send_item(read_item());
    send_item(tick_item(700));
    send_item(tick_item(700));
    send_item(tick_item(700));
    c.release_threshold = '0;
    c.valid_ceiling     = VAL_W'(1023);
    set_config(c);
    send_item(tick_item(1023));
    send_item(read_item());
    send_item(tick_item(1023));
    send_item(read_item());
  endtask

  // debounce wait that is not a whole number of ticks, run to the press
  task automatic test_debounce_wait();
    cfg_t c;
    c = regs;
    c.press_threshold   = VAL_W'(1023);
    c.release_threshold = '0;
    c.debounce_time_us  = TIME_W'(2050);
    c.repeat_time_us    = '0;
    set_config(c);
    no_gaps = 1;
    send_item(tick_item($urandom_range(0, 1023)));
    while (btn_state != BTN_PRESSED) begin
      if ($urandom_range(0, 99) < 5) send_item(read_item());
      else send_item(tick_item($urandom_range(0, 1023)));
    end
    send_item(read_item());
    send_item(tick_item(0));
    no_gaps = 0;
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    cfg_t c;
    c = regs;
    c.press_threshold   = VAL_W'(400);
    c.release_threshold = VAL_W'(800);
    c.debounce_time_us  = TIME_W'(300);
    c.repeat_time_us    = TIME_W'(200);
    set_config(c);
    hold_cycles = 120;
    no_gaps = 1;
    repeat (40) begin
      if ($urandom_range(0, 99) < 15) send_item(read_item());
      else send_item(tick_item($urandom_range(0, 600)));
    end
    no_gaps = 0;
  endtask

  // press/hold/release sequences with noise, across several settings
  task automatic test_random();
    cfg_t c;
    int   n;
    int   level;
    for (int ph = 0; ph < 7; ph++) begin
      c = '0;
      if (ph == 1) begin
        c.press_threshold   = VAL_W'(1023);
        c.release_threshold = VAL_W'(1023);
        c.debounce_time_us  = TIME_W'(1000000);
        c.repeat_time_us    = TIME_W'(1000000);
        c.valid_ceiling     = VAL_W'(1023);
      end else if (ph > 1) begin
        c.press_threshold = VAL_W'($urandom_range(100, 600));
        if ($urandom_range(0, 99) < 80)
          c.release_threshold = VAL_W'($urandom_range(c.press_threshold + 50, 1023));
        else
          c.release_threshold = VAL_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 1))
          c.debounce_time_us = TIME_W'($urandom_range(0, 30) * TICK_US);
        else
          c.debounce_time_us = TIME_W'($urandom_range(0, 3000));
        if ($urandom_range(0, 99) < 30) c.repeat_time_us = '0;
        else c.repeat_time_us = TIME_W'($urandom_range(1, 1500));
        c.valid_ceiling = VAL_W'($urandom_range(0, 1023));
      end
      set_config(c);
      n = 0;
      while (n < 230) begin
        if ($urandom_range(0, 99) < 80) begin
          level = $urandom_range(0, c.press_threshold + 100);
          repeat ($urandom_range(4, 50)) begin
            if ($urandom_range(0, 99) < 12) send_item(read_item());
            else send_item(tick_item(level + $urandom_range(0, 40) - 20));
            n++;
          end
          repeat ($urandom_range(5, 25)) begin
            if ($urandom_range(0, 99) < 12) send_item(read_item());
            else send_item(tick_item($urandom_range(900, 1023)));
            n++;
          end
        end else begin
          repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(0, 1)) send_item(read_item());
            else send_item(tick_item($urandom_range(0, 1023)));
            n++;
          end
        end
      end
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 50) begin
          stall_lvl = 1'b0; stall_left = $urandom_range(1, 6);
        end else if (stall_pick < 60) begin
          stall_lvl = 1'b0; stall_left = $urandom_range(20, 80);
        end else if (stall_pick < 92) begin
          stall_lvl = 1'b1; stall_left = $urandom_range(1, 3);
        end else begin
          stall_lvl = 1'b1; stall_left = $urandom_range(10, 40);
        end
      end
      stall_left = stall_left - 1;
      out_stall <= stall_lvl;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction filt=%0d state=%0d read=%0d valid=%0d", $time,
                 out_item.filtered_value, out_item.button_state, out_item.read_value,
                 out_item.read_valid);
      end else begin
        want_res = expected_results.pop_front();
        if (out_item !== want_res) begin
          errors++;
          $display("%0t: mismatch expected filt=%0d state=%0d read=%0d valid=%0d", $time,
                   want_res.filtered_value, want_res.button_state, want_res.read_value,
                   want_res.read_valid);
          $display("%0t:          actual   filt=%0d state=%0d read=%0d valid=%0d", $time,
                   out_item.filtered_value, out_item.button_state, out_item.read_value,
                   out_item.read_valid);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;

    regs.press_threshold   = '0;
    regs.release_threshold = OUT_UP;
    regs.debounce_time_us  = DEBOUNCE_RST;
    regs.repeat_time_us    = '0;
    regs.valid_ceiling     = OUT_UP;
    integ_acc = ACC_RESET;
    btn_state = BTN_UP;
    elapsed_q = '0;
    held_val  = '0;
    pub_val   = OUT_UP;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_field_extremes();
    test_debounce_wait();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/abfd_pkg.sv
src/abfd_core.sv
src/adc_button_filter_debounce_unit.sv
src/abfd_checker.sv
tb/sv/testbench.sv
